[sv/assert_macros.svh]
// Assertion helpers used by elm_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ELM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define ELM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/elm_pkg.sv]
`default_nettype none
package elm_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   // request modes
   localparam logic [1:0] MODE_HWEIGHT = 2'd0;
   localparam logic [1:0] MODE_BIAS    = 2'd1;
   localparam logic [1:0] MODE_OWEIGHT = 2'd2;
   localparam logic [1:0] MODE_FEATURE = 2'd3;

   // activation codes
   localparam logic [2:0] ACT_SIGMOID  = 3'd0;
   localparam logic [2:0] ACT_SINE     = 3'd1;
   localparam logic [2:0] ACT_HARDLIM  = 3'd2;
   localparam logic [2:0] ACT_TRIANGLE = 3'd3;
   localparam logic [2:0] ACT_RBF      = 3'd4;

   // csr indexes
   localparam logic [2:0] CSR_ACTIVATION = 3'd0;
   localparam logic [2:0] CSR_HIDDEN_CNT = 3'd1;
   localparam logic [2:0] CSR_FEATURE_CNT = 3'd2;
   localparam logic [2:0] CSR_RBF_CENTER = 3'd3;
   localparam logic [2:0] CSR_RBF_INVW   = 3'd4;

   // table selectors
   localparam int ROM_SIG = 0;
   localparam int ROM_SIN = 1;
   localparam int ROM_EXP = 2;

   localparam longint ONE_Q28    = 64'sd268435456;
   localparam longint EXP_M1_Q28 = 64'sd98751886;
   localparam longint PI_Q28     = 64'sd843314857;
   localparam longint TWO_PI_Q28 = 64'sd1686629713;
   localparam longint EXP_LIMIT_Q16 = 64'sd1048576;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } elm_state_type;

   typedef struct packed {
      logic hw_we;
      logic b_we;
      logic ow_we;
      logic x_we;
   } elm_wr_type;

   // tag that travels with each multiply-accumulate
   typedef struct packed {
      logic valid;
      logic first_f;
      logic last_f;
      logic first_n;
      logic last_n;
   } elm_tag_type;

   // tag that travels with each finished neuron
   typedef struct packed {
      logic valid;
      logic first_n;
      logic last_n;
   } elm_ntag_type;

   typedef struct packed {
      logic done;
   } elm_stat_type;

   typedef logic signed [15:0] rom_type [TABLE_DEPTH];

   // truncating quotient by shift and subtract, used only to fill the tables
   function automatic longint quot_trunc(longint n_val, longint d_val);
      logic [63:0] un;
      logic [63:0] ud;
      logic [63:0] q;
      logic [64:0] r;
      logic        neg;
      neg = (n_val < 0) != (d_val < 0);
      un  = (n_val < 0) ? 64'(-n_val) : 64'(n_val);
      ud  = (d_val < 0) ? 64'(-d_val) : 64'(d_val);
      q   = '0;
      r   = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], un[b]};
         if (r >= {1'b0, ud}) begin
            r    = r - {1'b0, ud};
            q[b] = 1'b1;
         end
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // exp(-t), t in Q16 below 16.0, result Q28
   function automatic longint exp_neg_q28(longint t16);
      longint k;
      longint f;
      longint r;
      longint sum;
      longint term;
      k    = t16 >>> 16;
      f    = (t16 & 64'sd65535) * 64'sd4096;
      r    = ONE_Q28;
      sum  = ONE_Q28;
      term = ONE_Q28;
      for (longint j = 0; j < k; j++) begin
         r = r * EXP_M1_Q28 / ONE_Q28;
      end
      for (longint j = 1; j <= 14; j++) begin
         term = quot_trunc(-(term * f / ONE_Q28), j);
         sum  = sum + term;
      end
      return r * sum / ONE_Q28;
   endfunction

   // sin(x), x in Q28 below 8.0 in magnitude, result Q28
   function automatic longint sin_q28(longint x_in);
      longint x;
      longint x2;
      longint sum;
      longint term;
      x = x_in;
      if (x > PI_Q28) x = x - TWO_PI_Q28;
      if (x < -PI_Q28) x = x + TWO_PI_Q28;
      x2   = x * x / ONE_Q28;
      sum  = x;
      term = x;
      for (longint k = 1; k <= 8; k++) begin
         term = quot_trunc(-(term * x2 / ONE_Q28), (2 * k) * (2 * k + 1));
         sum  = sum + term;
      end
      return sum;
   endfunction

   function automatic longint q28_to_q12(longint v);
      return (v >= 0) ? ((v + 64'sd32768) / 64'sd65536)
                      : -((-v + 64'sd32768) / 64'sd65536);
   endfunction

   function automatic rom_type build_rom(int sel);
      rom_type rom;
      longint  x;
      longint  mag;
      longint  e;
      longint  num;
      longint  den;
      longint  sv;
      longint  t;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         x = -64'sd32768 + (longint'(i) * 64'sd65536) / TABLE_DEPTH;
         if (sel == ROM_SIG) begin
            mag    = (x < 0) ? -x : x;
            e      = exp_neg_q28(mag * 16);
            num    = (x >= 0) ? ONE_Q28 : e;
            den    = ONE_Q28 + e;
            rom[i] = 16'(quot_trunc(num * 4096 + den / 2, den));
         end else if (sel == ROM_SIN) begin
            sv = q28_to_q12(sin_q28(x * 64'sd65536));
            if (sv > 4096) sv = 4096;
            if (sv < -4096) sv = -4096;
            rom[i] = 16'(sv);
         end else begin
            t      = (longint'(i) * EXP_LIMIT_Q16) / TABLE_DEPTH;
            rom[i] = 16'(q28_to_q12(exp_neg_q28(t)));
         end
      end
      return rom;
   endfunction

endpackage
`default_nettype wire

[sv/elm_ctrl.sv]
`default_nettype none
`include "assert_macros.svh"
module elm_ctrl import elm_pkg::*; #(
   parameter int MAX_HIDDEN   = 64,
   parameter int MAX_FEATURES = 16,
   parameter int NW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1,
   parameter int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic [1:0]    req_mode,
   input  wire logic [5:0]    req_neuron,
   input  wire logic [3:0]    req_feature,
   input  wire logic [6:0]    hidden_count,
   input  wire logic [4:0]    feature_count,
   output elm_wr_type         wr,
   output elm_tag_type        tag,
   output logic [NW-1:0]      rd_neuron,
   output logic [FW-1:0]      rd_feature,
   input  wire elm_stat_type  stat
);

   elm_state_type  state_ff, state_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [FW-1:0]  f_ff, f_in;
   logic [10:0]    hc_w;
   logic [8:0]     fc_w;
   logic [NW-1:0]  hc_last;
   logic [FW-1:0]  fc_last;
   logic           accept;
   logic           n_ok;
   logic           f_ok;
   logic           trigger;

   // effective last indexes: a zero count is taken as one, counts saturated to the store sizes
   always_comb begin
      hc_w = 11'(hidden_count);
      fc_w = 9'(feature_count);
      if (hc_w == 11'd0) begin
         hc_last = '0;
      end else if (hc_w > 11'(MAX_HIDDEN)) begin
         hc_last = NW'(MAX_HIDDEN - 1);
      end else begin
         hc_last = NW'(hc_w - 11'd1);
      end
      if (fc_w == 9'd0) begin
         fc_last = '0;
      end else if (fc_w > 9'(MAX_FEATURES)) begin
         fc_last = FW'(MAX_FEATURES - 1);
      end else begin
         fc_last = FW'(fc_w - 9'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
         f_ff     <= '0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         f_ff     <= f_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      f_in       = f_ff;
      busy       = (state_ff != ST_IDLE);
      accept     = start && (state_ff == ST_IDLE);
      n_ok       = 11'(req_neuron) < 11'(MAX_HIDDEN);
      f_ok       = 9'(req_feature) < 9'(MAX_FEATURES);
      wr.hw_we   = accept && (req_mode == MODE_HWEIGHT) && n_ok && f_ok;
      wr.b_we    = accept && (req_mode == MODE_BIAS) && n_ok;
      wr.ow_we   = accept && (req_mode == MODE_OWEIGHT) && n_ok;
      wr.x_we    = accept && (req_mode == MODE_FEATURE) && f_ok;
      trigger    = wr.x_we && (9'(req_feature) == 9'(fc_last));
      tag        = '0;
      rd_neuron  = n_ff;
      rd_feature = f_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (trigger) begin
               state_in = ST_RUN;
               n_in     = '0;
               f_in     = '0;
            end
         end
         ST_RUN: begin
            tag.valid   = 1'b1;
            tag.first_f = (f_ff == '0);
            tag.last_f  = (f_ff == fc_last);
            tag.first_n = (n_ff == '0);
            tag.last_n  = (n_ff == hc_last);
            if (tag.last_f) begin
               f_in = '0;
               if (tag.last_n) begin
                  state_in = ST_DRAIN;
               end else begin
                  n_in = n_ff + 1'b1;
               end
            end else begin
               f_in = f_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (stat.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ELM_ASSERT_SAME(a_done_in_drain, stat.done, state_ff == ST_DRAIN)
   `ELM_ASSERT_NEXT(a_trigger_runs, trigger, state_ff == ST_RUN && n_ff == '0 && f_ff == '0)
   `ELM_ASSERT_NEXT(a_done_idles, stat.done, state_ff == ST_IDLE)

endmodule
`default_nettype wire

[sv/elm_dp.sv]
`default_nettype none
module elm_dp import elm_pkg::*; #(
   parameter int MAX_HIDDEN   = 64,
   parameter int MAX_FEATURES = 16,
   parameter int NW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1,
   parameter int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [5:0]         req_neuron,
   input  wire logic [3:0]         req_feature,
   input  wire logic signed [15:0] req_value,
   input  wire elm_wr_type         wr,
   input  wire elm_tag_type        tag,
   input  wire logic [NW-1:0]      rd_neuron,
   input  wire logic [FW-1:0]      rd_feature,
   input  wire logic [2:0]         activation,
   input  wire logic signed [15:0] rbf_center,
   input  wire logic [15:0]        rbf_inv_width,
   output elm_stat_type            stat,
   output logic                    rsp_valid,
   output logic signed [47:0]      rsp_prediction
);

   localparam int ACC_W = 33 + FW;
   localparam rom_type SIG_ROM = build_rom(ROM_SIG);
   localparam rom_type SIN_ROM = build_rom(ROM_SIN);
   localparam rom_type EXP_ROM = build_rom(ROM_EXP);

   logic signed [15:0] hw_mem [MAX_HIDDEN * (2 ** FW)];
   logic signed [15:0] b_mem  [MAX_HIDDEN];
   logic signed [15:0] ow_mem [MAX_HIDDEN];
   logic signed [15:0] x_mem  [2 ** FW];

   logic [NW-1:0] wr_n;
   logic [FW-1:0] wr_f;

   // stage 1: memory reads
   logic signed [15:0] w1_ff, x1_ff, b1_ff, beta1_ff;
   elm_tag_type        tag1_ff;
   // stage 2: product
   logic signed [31:0] prod2_ff, prod2_in;
   logic signed [15:0] b2_ff, beta2_ff;
   elm_tag_type        tag2_ff;
   // stage 3: accumulate
   logic signed [ACC_W-1:0] acc3_ff, acc3_in;
   logic signed [15:0]      beta3_ff;
   elm_tag_type             tag3_ff;
   // stage 4: floored, saturated neuron sum
   logic signed [ACC_W-1:0] acc_sh;
   logic signed [15:0]      s4_ff, s4_in, beta4_ff;
   elm_ntag_type            n4_ff;
   // stage 5: squared distance
   logic signed [16:0] d;
   logic signed [33:0] d_sq;
   logic [32:0]        d2_5_ff;
   logic signed [15:0] s5_ff, beta5_ff;
   elm_ntag_type       n5_ff;
   // stage 6: scaled distance
   logic [48:0]        r6_ff, r6_in;
   logic signed [15:0] s6_ff, beta6_ff;
   elm_ntag_type       n6_ff;
   // stage 7: activation
   logic signed [15:0] act7_ff, act7_in, beta7_ff;
   logic [15:0]        s_off;
   logic [16:0]        s_mag;
   elm_ntag_type       n7_ff;
   // stage 8: output product
   logic signed [31:0] op8_ff, op8_in;
   elm_ntag_type       n8_ff;
   // stage 9: prediction sum
   logic signed [47:0] sum_ff, sum_in;
   logic               rsp_valid_ff;

   assign wr_n = NW'(req_neuron);
   assign wr_f = FW'(req_feature);

   always_ff @(posedge clock) begin
      if (wr.hw_we) hw_mem[{wr_n, wr_f}] <= req_value;
      if (wr.b_we)  b_mem[wr_n]          <= req_value;
      if (wr.ow_we) ow_mem[wr_n]         <= req_value;
      if (wr.x_we)  x_mem[wr_f]          <= req_value;
      w1_ff    <= hw_mem[{rd_neuron, rd_feature}];
      x1_ff    <= x_mem[rd_feature];
      b1_ff    <= b_mem[rd_neuron];
      beta1_ff <= ow_mem[rd_neuron];
   end

   always_comb begin
      prod2_in = w1_ff * x1_ff;
      acc3_in  = (tag2_ff.first_f ? (ACC_W'(b2_ff) <<< 12) : acc3_ff) + ACC_W'(prod2_ff);
      acc_sh   = acc3_ff >>> 12;
      if (acc_sh > ACC_W'(32767)) begin
         s4_in = 16'sh7FFF;
      end else if (acc_sh < -ACC_W'(32768)) begin
         s4_in = -16'sh8000;
      end else begin
         s4_in = 16'(acc_sh);
      end
      d     = 17'(s4_ff) - 17'(rbf_center);
      d_sq  = d * d;
      r6_in = d2_5_ff * rbf_inv_width;
      s_off = {~s6_ff[15], s6_ff[14:0]};
      s_mag = s6_ff[15] ? -17'(s6_ff) : 17'(s6_ff);
      unique case (activation)
         ACT_SIGMOID:  act7_in = SIG_ROM[s_off[15 -: IDX_W]];
         ACT_SINE:     act7_in = SIN_ROM[s_off[15 -: IDX_W]];
         ACT_HARDLIM:  act7_in = (s6_ff > 16'sd0) ? 16'sd4096 : 16'sd0;
         ACT_TRIANGLE: act7_in = (s_mag <= 17'd4096) ? 16'(17'd4096 - s_mag) : 16'sd0;
         ACT_RBF:      act7_in = (r6_ff[48:40] != '0) ? 16'sd0 : EXP_ROM[r6_ff[39 -: IDX_W]];
         default:      act7_in = 16'sd0;
      endcase
      op8_in = act7_ff * beta7_ff;
      sum_in = n8_ff.first_n ? 48'(op8_ff) : sum_ff + 48'(op8_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         n4_ff        <= '0;
         n5_ff        <= '0;
         n6_ff        <= '0;
         n7_ff        <= '0;
         n8_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag1_ff      <= tag;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
         n4_ff        <= '{valid: tag3_ff.valid && tag3_ff.last_f,
                           first_n: tag3_ff.first_n, last_n: tag3_ff.last_n};
         n5_ff        <= n4_ff;
         n6_ff        <= n5_ff;
         n7_ff        <= n6_ff;
         n8_ff        <= n7_ff;
         rsp_valid_ff <= n8_ff.valid && n8_ff.last_n;
      end
   end

   always_ff @(posedge clock) begin
      prod2_ff <= prod2_in;
      b2_ff    <= b1_ff;
      beta2_ff <= beta1_ff;
      if (tag2_ff.valid) acc3_ff <= acc3_in;
      beta3_ff <= beta2_ff;
      s4_ff    <= s4_in;
      beta4_ff <= beta3_ff;
      d2_5_ff  <= 33'(d_sq);
      s5_ff    <= s4_ff;
      beta5_ff <= beta4_ff;
      r6_ff    <= r6_in;
      s6_ff    <= s5_ff;
      beta6_ff <= beta5_ff;
      act7_ff  <= act7_in;
      beta7_ff <= beta6_ff;
      op8_ff   <= op8_in;
      if (n8_ff.valid) sum_ff <= sum_in;
   end

   assign stat.done      = rsp_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = sum_ff;

endmodule
`default_nettype wire

[sv/elm_hidden_layer_inference_top.sv]
// Load items (weights, biases, output weights) and feature samples are written while idle.
// The sample that completes a point starts the multiply-accumulate over the configured
// neurons and features, one product per cycle from the weight memory read port;
// rsp_valid rises once the last neuron's output product has been summed.
// busy drops the cycle after that strobe. Synchronous reset clears control, the valid tags
// and the CSRs; data registers are not reset, and stores hold nothing until written.
`default_nettype none
module elm_hidden_layer_inference_top import elm_pkg::*; #(
   parameter int MAX_HIDDEN   = 64,
   parameter int MAX_FEATURES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic [5:0]         req_neuron,
   input  wire logic [3:0]         req_feature,
   input  wire logic signed [15:0] req_value,
   output logic                    rsp_valid,
   output logic signed [47:0]      rsp_prediction,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   localparam int NW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
   localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

   logic [2:0]         activation_ff;
   logic [6:0]         hidden_count_ff;
   logic [4:0]         feature_count_ff;
   logic signed [15:0] rbf_center_ff;
   logic [15:0]        rbf_inv_width_ff;

   elm_wr_type    wr;
   elm_tag_type   tag;
   elm_stat_type  stat;
   logic [NW-1:0] rd_neuron;
   logic [FW-1:0] rd_feature;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         activation_ff    <= ACT_SIGMOID;
         hidden_count_ff  <= 7'd64;
         feature_count_ff <= 5'd16;
         rbf_center_ff    <= '0;
         rbf_inv_width_ff <= 16'd4096;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ACTIVATION:  activation_ff    <= csr_data[2:0];
            CSR_HIDDEN_CNT:  hidden_count_ff  <= csr_data[6:0];
            CSR_FEATURE_CNT: feature_count_ff <= csr_data[4:0];
            CSR_RBF_CENTER:  rbf_center_ff    <= csr_data;
            CSR_RBF_INVW:    rbf_inv_width_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   elm_ctrl #(
      .MAX_HIDDEN   (MAX_HIDDEN),
      .MAX_FEATURES (MAX_FEATURES),
      .NW           (NW),
      .FW           (FW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_neuron    (req_neuron),
      .req_feature   (req_feature),
      .hidden_count  (hidden_count_ff),
      .feature_count (feature_count_ff),
      .wr            (wr),
      .tag           (tag),
      .rd_neuron     (rd_neuron),
      .rd_feature    (rd_feature),
      .stat          (stat)
   );

   elm_dp #(
      .MAX_HIDDEN   (MAX_HIDDEN),
      .MAX_FEATURES (MAX_FEATURES),
      .NW           (NW),
      .FW           (FW)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_neuron     (req_neuron),
      .req_feature    (req_feature),
      .req_value      (req_value),
      .wr             (wr),
      .tag            (tag),
      .rd_neuron      (rd_neuron),
      .rd_feature     (rd_feature),
      .activation     (activation_ff),
      .rbf_center     (rbf_center_ff),
      .rbf_inv_width  (rbf_inv_width_ff),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_prediction (rsp_prediction)
   );

endmodule
`default_nettype wire
